>>> rtl/core/dgt_pkg.sv
`timescale 1ns / 1ps

package dgt_pkg;

	// Grid limits
	localparam int MAX_WIDTH  = 1024;
	localparam int MAX_HEIGHT = 1024;
	localparam int COL_W      = $clog2(MAX_WIDTH);
	localparam int ROW_W      = $clog2(MAX_HEIGHT);
	localparam int WEFF_W     = $clog2(MAX_WIDTH + 1);
	localparam int HEFF_W     = $clog2(MAX_HEIGHT + 1);

	// Field widths
	localparam int DIM_W   = 11;
	localparam int THR_W   = 32;
	localparam int COORD_W = 32;
	localparam int DIFF_W  = COORD_W + 1;
	localparam int MAG_W   = COORD_W;
	localparam int SQ_W    = 2 * MAG_W;
	localparam int SUM_W   = SQ_W + 2;
	localparam int IDX_W   = 20;

	// Configuration port
	localparam int APB_ADDR_W = 4;
	localparam int APB_DATA_W = 32;
	localparam logic [1:0] REG_IMAGE_WIDTH    = 2'd0;
	localparam logic [1:0] REG_IMAGE_HEIGHT   = 2'd1;
	localparam logic [1:0] REG_EDGE_THRESHOLD = 2'd2;
	localparam logic [DIM_W-1:0] RST_IMAGE_WIDTH    = DIM_W'(640);
	localparam logic [DIM_W-1:0] RST_IMAGE_HEIGHT   = DIM_W'(480);
	localparam logic [THR_W-1:0] RST_EDGE_THRESHOLD = THR_W'(45875);

	// Queue between front and back
	localparam int QUEUE_DEPTH = 8;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// Cell corners and the edges between them
	typedef enum logic [1:0] {
		CRN_UL,
		CRN_UR,
		CRN_LL,
		CRN_LR
	} corner_t;

	localparam int N_CORNERS = 4;
	localparam int N_EDGES   = 6;
	localparam int N_AXES    = 3;
	localparam int E_UL_UR = 0;
	localparam int E_UR_LR = 1;
	localparam int E_UL_LR = 2;
	localparam int E_LR_LL = 3;
	localparam int E_LL_UL = 4;
	localparam int E_UR_LL = 5;
	localparam corner_t EDGE_P [N_EDGES] = '{CRN_UL, CRN_UR, CRN_UL, CRN_LR, CRN_LL, CRN_UR};
	localparam corner_t EDGE_Q [N_EDGES] = '{CRN_UR, CRN_LR, CRN_LR, CRN_LL, CRN_UL, CRN_LL};

	typedef struct packed {
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
		logic signed [COORD_W-1:0] z;
	} point_t;

	typedef struct packed {
		logic [DIM_W-1:0] image_width;
		logic [DIM_W-1:0] image_height;
		logic [THR_W-1:0] edge_threshold;
	} cfg_t;

	typedef struct packed {
		logic [IDX_W-1:0] a;
		logic [IDX_W-1:0] b;
		logic [IDX_W-1:0] c;
	} tri_t;

	// One queued point: its first triangle, an optional second one
	typedef struct packed {
		tri_t first;
		tri_t second;
		logic two;
	} q_entry_t;

endpackage

>>> rtl/core/dgt_ifs.sv
`timescale 1ns / 1ps

// Point stream channel
interface dgt_point_if;
	logic valid;
	logic ready;
	logic signed [dgt_pkg::COORD_W-1:0] point_x;
	logic signed [dgt_pkg::COORD_W-1:0] point_y;
	logic signed [dgt_pkg::COORD_W-1:0] point_z;

	modport source(output valid, output point_x, output point_y, output point_z, input ready);
	modport sink(input valid, input point_x, input point_y, input point_z, output ready);
endinterface

// Triangle stream channel
interface dgt_tri_if;
	logic valid;
	logic ready;
	logic [dgt_pkg::IDX_W-1:0] vertex_a;
	logic [dgt_pkg::IDX_W-1:0] vertex_b;
	logic [dgt_pkg::IDX_W-1:0] vertex_c;
	logic last_of_run;

	modport source(output valid, output vertex_a, output vertex_b, output vertex_c,
		output last_of_run, input ready);
	modport sink(input valid, input vertex_a, input vertex_b, input vertex_c,
		input last_of_run, output ready);
endinterface

>>> rtl/core/dgt_cfg.sv
`timescale 1ns / 1ps

module dgt_cfg (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [dgt_pkg::APB_ADDR_W-1:0] paddr,
	input  logic [dgt_pkg::APB_DATA_W-1:0] pwdata,
	output logic [dgt_pkg::APB_DATA_W-1:0] prdata,
	output logic                          pready,
	output dgt_pkg::cfg_t                 cfg
);
	import dgt_pkg::*;

	logic [DIM_W-1:0] width_q;
	logic [DIM_W-1:0] height_q;
	logic [THR_W-1:0] thr_q;
	logic [1:0]       reg_idx;
	logic             wr_en;

	assign reg_idx = paddr[3:2];
	assign wr_en   = psel && penable && pwrite;
	assign pready  = 1'b1;

	// Register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= RST_IMAGE_WIDTH;
			height_q <= RST_IMAGE_HEIGHT;
			thr_q    <= RST_EDGE_THRESHOLD;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_IMAGE_WIDTH: begin
					width_q <= pwdata[DIM_W-1:0];
				end
				REG_IMAGE_HEIGHT: begin
					height_q <= pwdata[DIM_W-1:0];
				end
				REG_EDGE_THRESHOLD: begin
					thr_q <= pwdata[THR_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// Read mux
	always_comb begin
		unique case (reg_idx)
			REG_IMAGE_WIDTH: begin
				prdata = APB_DATA_W'(width_q);
			end
			REG_IMAGE_HEIGHT: begin
				prdata = APB_DATA_W'(height_q);
			end
			REG_EDGE_THRESHOLD: begin
				prdata = APB_DATA_W'(thr_q);
			end
			default: begin
				prdata = '0;
			end
		endcase
	end

	assign cfg.image_width    = width_q;
	assign cfg.image_height   = height_q;
	assign cfg.edge_threshold = thr_q;

endmodule

>>> rtl/core/dgt_front.sv
`timescale 1ns / 1ps

module dgt_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  dgt_pkg::cfg_t        cfg,
	dgt_point_if.sink            point_in,
	input  logic                 q_pop,
	output logic                 q_push,
	output dgt_pkg::q_entry_t    q_data
);
	import dgt_pkg::*;

	function automatic logic signed [COORD_W-1:0] axis_of(point_t p, int k);
		logic signed [COORD_W-1:0] v;
		case (k)
			0:       v = p.x;
			1:       v = p.y;
			default: v = p.z;
		endcase
		return v;
	endfunction

	// Effective grid size, clamped to [2, MAX]
	logic [WEFF_W-1:0] w_eff;
	logic [HEFF_W-1:0] h_eff;

	always_comb begin
		priority if (cfg.image_width < DIM_W'(2)) begin
			w_eff = WEFF_W'(2);
		end else if (32'(cfg.image_width) > MAX_WIDTH) begin
			w_eff = WEFF_W'(MAX_WIDTH);
		end else begin
			w_eff = WEFF_W'(cfg.image_width);
		end
		priority if (cfg.image_height < DIM_W'(2)) begin
			h_eff = HEFF_W'(2);
		end else if (32'(cfg.image_height) > MAX_HEIGHT) begin
			h_eff = HEFF_W'(MAX_HEIGHT);
		end else begin
			h_eff = HEFF_W'(cfg.image_height);
		end
	end

	// Squared threshold, registered
	logic [SQ_W-1:0] lim_q;

	always_ff @(posedge clk) begin
		lim_q <= SQ_W'(cfg.edge_threshold) * SQ_W'(cfg.edge_threshold);
	end

	// Credit count: accepted points not yet dropped or popped from the queue
	logic [QCNT_W-1:0] used_q;
	logic              acc;
	logic              drop;

	assign point_in.ready = used_q < QCNT_W'(QUEUE_DEPTH);
	assign acc            = point_in.valid && point_in.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= '0;
		end else begin
			used_q <= used_q + QCNT_W'(acc) - QCNT_W'(q_pop) - QCNT_W'(drop);
		end
	end

	// Grid position counters
	logic [COL_W-1:0] col_q;
	logic [ROW_W-1:0] row_q;
	logic             col_wrap;
	logic             row_wrap;

	assign col_wrap = (32'(col_q) + 1) >= 32'(w_eff);
	assign row_wrap = (32'(row_q) + 1) >= 32'(h_eff);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (acc) begin
			if (col_wrap) begin
				col_q <= '0;
				row_q <= row_wrap ? '0 : row_q + ROW_W'(1);
			end else begin
				col_q <= col_q + COL_W'(1);
			end
		end
	end

	// Lower left pixel index of the cell that this point closes
	logic [ROW_W+WEFF_W-1:0] row_base;
	logic [IDX_W-1:0]        ll_idx;
	point_t                  cur;

	assign row_base = {{WEFF_W{1'b0}}, row_q} * {{ROW_W{1'b0}}, w_eff};
	assign ll_idx   = IDX_W'(row_base) + IDX_W'(col_q) - IDX_W'(1);
	assign cur.x    = point_in.point_x;
	assign cur.y    = point_in.point_y;
	assign cur.z    = point_in.point_z;

	// Stage 1: line buffer read and corner capture
	point_t row_mem [MAX_WIDTH];
	point_t ur_s1;
	point_t ul_s1;
	point_t ll_s1;
	point_t lr_s1;
	logic [IDX_W-1:0] ll_idx_s1;
	logic             cell_s1;
	logic             even_s1;
	logic             v_s1;

	always_ff @(posedge clk) begin
		if (acc) begin
			ur_s1          <= row_mem[col_q];
			row_mem[col_q] <= cur;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			lr_s1     <= cur;
			ll_s1     <= lr_s1;
			ul_s1     <= ur_s1;
			ll_idx_s1 <= ll_idx;
			cell_s1   <= (row_q != '0) && (col_q != '0);
			even_s1   <= (row_q[0] ^ col_q[0]) == 1'b0;
		end
	end

	// Stage 2: per-axis squared differences on every edge
	point_t                   crn [N_CORNERS];
	logic signed [DIFF_W-1:0] diff [N_EDGES][N_AXES];
	logic [MAG_W-1:0]         mag  [N_EDGES][N_AXES];
	logic [SQ_W-1:0]          sq_s2 [N_EDGES][N_AXES];
	logic [IDX_W-1:0]         ul_idx_s2;
	logic [IDX_W-1:0]         ur_idx_s2;
	logic [IDX_W-1:0]         ll_idx_s2;
	logic [IDX_W-1:0]         lr_idx_s2;
	logic                     cell_s2;
	logic                     even_s2;
	logic                     v_s2;

	always_comb begin
		crn[CRN_UL] = ul_s1;
		crn[CRN_UR] = ur_s1;
		crn[CRN_LL] = ll_s1;
		crn[CRN_LR] = lr_s1;
		for (int e = 0; e < N_EDGES; e++) begin
			for (int k = 0; k < N_AXES; k++) begin
				diff[e][k] = DIFF_W'(axis_of(crn[EDGE_P[e]], k))
					- DIFF_W'(axis_of(crn[EDGE_Q[e]], k));
				mag[e][k]  = diff[e][k][DIFF_W-1] ? MAG_W'(-diff[e][k]) : MAG_W'(diff[e][k]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (v_s1) begin
			for (int e = 0; e < N_EDGES; e++) begin
				for (int k = 0; k < N_AXES; k++) begin
					sq_s2[e][k] <= SQ_W'(mag[e][k]) * SQ_W'(mag[e][k]);
				end
			end
			ul_idx_s2 <= ll_idx_s1 - IDX_W'(w_eff);
			ur_idx_s2 <= ll_idx_s1 - IDX_W'(w_eff) + IDX_W'(1);
			ll_idx_s2 <= ll_idx_s1;
			lr_idx_s2 <= ll_idx_s1 + IDX_W'(1);
			cell_s2   <= cell_s1;
			even_s2   <= even_s1;
		end
	end

	// Stage 3: squared edge lengths
	logic [SUM_W-1:0] sum_s3 [N_EDGES];
	logic [IDX_W-1:0] ul_idx_s3;
	logic [IDX_W-1:0] ur_idx_s3;
	logic [IDX_W-1:0] ll_idx_s3;
	logic [IDX_W-1:0] lr_idx_s3;
	logic             cell_s3;
	logic             even_s3;
	logic             v_s3;

	always_ff @(posedge clk) begin
		if (v_s2) begin
			for (int e = 0; e < N_EDGES; e++) begin
				sum_s3[e] <= SUM_W'(sq_s2[e][0]) + SUM_W'(sq_s2[e][1]) + SUM_W'(sq_s2[e][2]);
			end
			ul_idx_s3 <= ul_idx_s2;
			ur_idx_s3 <= ur_idx_s2;
			ll_idx_s3 <= ll_idx_s2;
			lr_idx_s3 <= lr_idx_s2;
			cell_s3   <= cell_s2;
			even_s3   <= even_s2;
		end
	end

	// Stage valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= acc;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// Edge tests, triangle selection and queue write
	logic [N_EDGES-1:0] eok;
	logic               ok1;
	logic               ok2;
	tri_t               t1;
	tri_t               t2;

	always_comb begin
		for (int e = 0; e < N_EDGES; e++) begin
			eok[e] = sum_s3[e] <= SUM_W'(lim_q);
		end
		if (even_s3) begin
			ok1 = eok[E_UL_UR] && eok[E_UR_LR] && eok[E_UL_LR];
			ok2 = eok[E_UL_LR] && eok[E_LR_LL] && eok[E_LL_UL];
			t1  = '{a: ul_idx_s3, b: ur_idx_s3, c: lr_idx_s3};
			t2  = '{a: ul_idx_s3, b: lr_idx_s3, c: ll_idx_s3};
		end else begin
			ok1 = eok[E_UL_UR] && eok[E_UR_LL] && eok[E_LL_UL];
			ok2 = eok[E_UR_LL] && eok[E_UR_LR] && eok[E_LR_LL];
			t1  = '{a: ul_idx_s3, b: ur_idx_s3, c: ll_idx_s3};
			t2  = '{a: ll_idx_s3, b: ur_idx_s3, c: lr_idx_s3};
		end
	end

	assign q_push        = v_s3 && cell_s3 && (ok1 || ok2);
	assign drop          = v_s3 && !(cell_s3 && (ok1 || ok2));
	assign q_data.first  = ok1 ? t1 : t2;
	assign q_data.second = t2;
	assign q_data.two    = ok1 && ok2;

endmodule

>>> rtl/core/dgt_queue.sv
`timescale 1ns / 1ps

module dgt_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  dgt_pkg::q_entry_t push_data,
	input  logic              pop,
	output logic              head_valid,
	output dgt_pkg::q_entry_t head
);
	import dgt_pkg::*;

	q_entry_t          slots [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	// Entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			slots[wr_ptr_q] <= push_data;
		end
	end

	// Pointers and fill level; the front's credits keep it from overflowing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			count_q <= count_q + QCNT_W'(push) - QCNT_W'(pop);
		end
	end

	assign head_valid = count_q != '0;
	assign head       = slots[rd_ptr_q];

endmodule

>>> rtl/core/dgt_back.sv
`timescale 1ns / 1ps

module dgt_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              head_valid,
	input  dgt_pkg::q_entry_t head,
	output logic              pop,
	dgt_tri_if.source         tri_out
);
	import dgt_pkg::*;

	tri_t out_tri_q;
	logic out_last_q;
	logic out_valid_q;
	logic second_q;
	logic load;
	logic last_now;

	// Output register takes a triangle when empty or being drained
	assign load     = head_valid && (!out_valid_q || tri_out.ready);
	assign last_now = !head.two || second_q;
	assign pop      = load && last_now;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			second_q    <= 1'b0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
				second_q    <= head.two && !second_q;
			end else if (tri_out.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_tri_q  <= second_q ? head.second : head.first;
			out_last_q <= last_now;
		end
	end

	assign tri_out.valid       = out_valid_q;
	assign tri_out.vertex_a    = out_tri_q.a;
	assign tri_out.vertex_b    = out_tri_q.b;
	assign tri_out.vertex_c    = out_tri_q.c;
	assign tri_out.last_of_run = out_last_q;

endmodule

>>> rtl/core/depth_grid_triangulator_unit.sv
`timescale 1ns / 1ps

// Grid triangulator for an organized point cloud. Points (signed Q16.16 x, y, z) enter
// on point_in in row-major order, one per cycle sustained; each point from the second
// row and second column on closes one grid cell, which is split into two triangles along
// a diagonal that alternates with row plus column parity. A triangle leaves on tri_out as
// three pixel indices (row * width + column) only when all three squared edge lengths are
// at most edge_threshold squared; last_of_run marks the final triangle of a point. A
// point's triangles pass the line buffer read, squares, sums and compare steps on
// their way into the output queue, and then the output register, before they are
// presented. The output side moves one triangle per cycle while tri_out.ready is high,
// so a cell that yields two triangles presents them one after the other; an
// eight-entry credit budget covers the points in the pipeline and the queue,
// and point_in backpressures only when that budget is spent. Registers over APB:
// image_width at 0x0, image_height at 0x4, edge_threshold at 0x8; width and height are
// clamped to [2, 1024] and should be changed only between frames while the block is idle.
module depth_grid_triangulator_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [dgt_pkg::APB_ADDR_W-1:0] paddr,
	input  logic [dgt_pkg::APB_DATA_W-1:0] pwdata,
	output logic [dgt_pkg::APB_DATA_W-1:0] prdata,
	output logic                          pready,
	dgt_point_if.sink                     point_in,
	dgt_tri_if.source                     tri_out
);
	import dgt_pkg::*;

	cfg_t     cfg;
	logic     q_push;
	q_entry_t q_data;
	logic     q_pop;
	logic     head_valid;
	q_entry_t head;

	// Register file
	dgt_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Point intake, line buffer and edge tests
	dgt_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.point_in (point_in),
		.q_pop    (q_pop),
		.q_push   (q_push),
		.q_data   (q_data)
	);

	// Queue of accepted cells
	dgt_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_data  (q_data),
		.pop        (q_pop),
		.head_valid (head_valid),
		.head       (head)
	);

	// Triangle output
	dgt_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head       (head),
		.pop        (q_pop),
		.tri_out    (tri_out)
	);

endmodule

>>> verif/dgt_mesh_checker.sv
`timescale 1ns / 1ps

module dgt_mesh_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [dgt_pkg::APB_ADDR_W-1:0] paddr,
	input  logic [dgt_pkg::APB_DATA_W-1:0] pwdata,
	input  logic [dgt_pkg::APB_DATA_W-1:0] prdata,
	input  logic                           pready,
	dgt_point_if                           pts,
	dgt_tri_if                             tris,
	output int                             fail_count,
	output int                             results_pending,
	output int                             points_seen,
	output int                             tris_checked
);
	import dgt_pkg::*;

	typedef struct packed {
		tri_t corners;
		logic last;
	} tri_expect_t;

	// Shadow of the block: registers, previous row and the 2x2 window
	cfg_t        cfg;
	point_t      prev_row [MAX_WIDTH];
	point_t      left_pt;
	point_t      upleft_pt;
	int          col_pos;
	int          row_pos;
	tri_expect_t tri_fifo [$];
	int          fails;
	int          pts_done;
	int          tris_done;

	function automatic int dim_in_use(logic [DIM_W-1:0] v, int hi);
		if (v < 2)
			return 2;
		if (v > hi)
			return hi;
		return int'(v);
	endfunction

	// Squared difference on one axis, Q32.32
	function automatic logic [SQ_W-1:0] axis_sq(logic signed [COORD_W-1:0] a,
		logic signed [COORD_W-1:0] b);
		logic [DIFF_W-1:0] d;
		logic [MAG_W-1:0]  m;
		d = {a[COORD_W-1], a} - {b[COORD_W-1], b};
		m = d[DIFF_W-1] ? MAG_W'(-d) : MAG_W'(d);
		return {{MAG_W{1'b0}}, m} * {{MAG_W{1'b0}}, m};
	endfunction

	// Full-width sum, as wide as the block's, so no edge length can overflow
	function automatic logic edge_fits(point_t p, point_t q, logic [SQ_W-1:0] lim);
		logic [SUM_W-1:0] len_sq;
		len_sq = SUM_W'(axis_sq(p.x, q.x)) + SUM_W'(axis_sq(p.y, q.y))
			+ SUM_W'(axis_sq(p.z, q.z));
		return len_sq <= SUM_W'(lim);
	endfunction

	function automatic logic tri_fits(point_t p, point_t q, point_t r, logic [SQ_W-1:0] lim);
		return edge_fits(p, q, lim) && edge_fits(q, r, lim) && edge_fits(r, p, lim);
	endfunction

	function automatic tri_expect_t make_tri(int a, int b, int c);
		tri_expect_t t;
		t.corners.a = IDX_W'(a);
		t.corners.b = IDX_W'(b);
		t.corners.c = IDX_W'(c);
		t.last      = 1'b0;
		return t;
	endfunction

	function automatic logic [APB_DATA_W-1:0] reg_value(logic [1:0] idx);
		case (idx)
			REG_IMAGE_WIDTH:    return APB_DATA_W'(cfg.image_width);
			REG_IMAGE_HEIGHT:   return APB_DATA_W'(cfg.image_height);
			REG_EDGE_THRESHOLD: return APB_DATA_W'(cfg.edge_threshold);
			default:            return '0;
		endcase
	endfunction

	task automatic compare_field(string name, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, actual %0d", name, want, got);
			fails++;
		end
	endtask

	// Closes the cell left-above the new point and queues the triangles that pass
	task automatic predict_point(point_t cur);
		int          w;
		int          h;
		int          col;
		int          row;
		int          ul;
		int          ll;
		logic [SQ_W-1:0] lim;
		point_t      above;
		tri_expect_t found [2];
		int          n_found;
		w       = dim_in_use(cfg.image_width, MAX_WIDTH);
		h       = dim_in_use(cfg.image_height, MAX_HEIGHT);
		lim     = SQ_W'(cfg.edge_threshold) * SQ_W'(cfg.edge_threshold);
		col     = col_pos;
		row     = row_pos;
		above   = prev_row[col];
		n_found = 0;
		if (row >= 1 && col >= 1) begin
			ul = (row - 1) * w + col - 1;
			ll = row * w + col - 1;
			// diagonal flips with cell parity
			if (((row + col) % 2) == 0) begin
				if (tri_fits(upleft_pt, above, cur, lim)) begin
					found[n_found] = make_tri(ul, ul + 1, ll + 1);
					n_found++;
				end
				if (tri_fits(upleft_pt, cur, left_pt, lim)) begin
					found[n_found] = make_tri(ul, ll + 1, ll);
					n_found++;
				end
			end else begin
				if (tri_fits(upleft_pt, above, left_pt, lim)) begin
					found[n_found] = make_tri(ul, ul + 1, ll);
					n_found++;
				end
				if (tri_fits(left_pt, above, cur, lim)) begin
					found[n_found] = make_tri(ll, ul + 1, ll + 1);
					n_found++;
				end
			end
			for (int k = 0; k < n_found; k++) begin
				found[k].last = (k == n_found - 1);
				tri_fifo = {tri_fifo, found[k]};
			end
		end
		upleft_pt     = above;
		prev_row[col] = cur;
		left_pt       = cur;
		if (col + 1 >= w) begin
			col_pos = 0;
			row_pos = (row + 1 >= h) ? 0 : row + 1;
		end else begin
			col_pos = col + 1;
		end
	endtask

	task automatic check_triangle();
		tri_expect_t want;
		if (tri_fifo.size() == 0) begin
			$error("triangle %0d %0d %0d arrived with nothing expected",
				tris.vertex_a, tris.vertex_b, tris.vertex_c);
			fails++;
		end else begin
			want = tri_fifo.pop_front();
			compare_field("vertex_a", want.corners.a, tris.vertex_a);
			compare_field("vertex_b", want.corners.b, tris.vertex_b);
			compare_field("vertex_c", want.corners.c, tris.vertex_c);
			compare_field("last_of_run", want.last, tris.last_of_run);
		end
		tris_done++;
	endtask

	// Watch both streams and the register port
	always @(posedge clk or negedge arst_n) begin : monitor
		logic [1:0] reg_idx;
		if (!arst_n) begin
			cfg.image_width    = RST_IMAGE_WIDTH;
			cfg.image_height   = RST_IMAGE_HEIGHT;
			cfg.edge_threshold = RST_EDGE_THRESHOLD;
			for (int k = 0; k < MAX_WIDTH; k++)
				prev_row[k] = '0;
			left_pt   = '0;
			upleft_pt = '0;
			col_pos   = 0;
			row_pos   = 0;
			tri_fifo.delete();
			fails     = 0;
			pts_done  = 0;
			tris_done = 0;
		end else begin
			// output first: a triangle can never come from a point taken at this edge
			if (tris.valid && tris.ready)
				check_triangle();
			if (pts.valid && pts.ready) begin
				predict_point({pts.point_x, pts.point_y, pts.point_z});
				pts_done++;
			end
			if (psel && penable && pready) begin
				reg_idx = paddr[APB_ADDR_W-1:2];
				if (pwrite) begin
					case (reg_idx)
						REG_IMAGE_WIDTH:    cfg.image_width    = pwdata[DIM_W-1:0];
						REG_IMAGE_HEIGHT:   cfg.image_height   = pwdata[DIM_W-1:0];
						REG_EDGE_THRESHOLD: cfg.edge_threshold = pwdata[THR_W-1:0];
						default: ;
					endcase
				end else begin
					compare_field("prdata", reg_value(reg_idx), prdata);
				end
			end
		end
		fail_count      <= fails;
		results_pending <= tri_fifo.size();
		points_seen     <= pts_done;
		tris_checked    <= tris_done;
	end

endmodule

>>> verif/tb_depth_grid_triangulator_unit.sv
`timescale 1ns / 1ps

module tb_depth_grid_triangulator_unit;
	import dgt_pkg::*;

	localparam int CYCLE_LIMIT  = 3_000_000;
	localparam int DRAIN_CYCLES = 16;
	localparam int RANDOM_ITEMS = 830;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [APB_ADDR_W-1:0] paddr;
	logic [APB_DATA_W-1:0] pwdata;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;

	int fail_count;
	int results_pending;
	int points_seen;
	int tris_checked;
	int settings_used = 0;
	int cycle_count;

	dgt_point_if pts();
	dgt_tri_if   tris();

	depth_grid_triangulator_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.point_in (pts),
		.tri_out  (tris)
	);

	dgt_mesh_checker mesh_check (
		.clk             (clk),
		.arst_n          (arst_n),
		.psel            (psel),
		.penable         (penable),
		.pwrite          (pwrite),
		.paddr           (paddr),
		.pwdata          (pwdata),
		.prdata          (prdata),
		.pready          (pready),
		.pts             (pts),
		.tris            (tris),
		.fail_count      (fail_count),
		.results_pending (results_pending),
		.points_seen     (points_seen),
		.tris_checked    (tris_checked)
	);

	always #5 clk = ~clk;

	// Mostly back-to-back, some short gaps, a few long ones
	function automatic int idle_len();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 55)
			return 0;
		if (pick < 93)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Register value that acts as the wanted size; sizes at the clamps may get out-of-range values
	function automatic logic [DIM_W-1:0] dim_reg_for(int eff, int hi);
		int pick;
		pick = $urandom_range(0, 2);
		if (eff <= 2)
			return DIM_W'(pick);
		if (eff >= hi)
			return (pick == 0) ? DIM_W'(hi) : (pick == 1) ? '1 : DIM_W'($urandom_range(hi, 2047));
		return DIM_W'(eff);
	endfunction

	// One APB transfer; always ends with the bus returned to idle
	task automatic apb_xfer(logic is_write, logic [1:0] reg_idx, logic [APB_DATA_W-1:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= is_write;
		paddr   <= APB_ADDR_W'({reg_idx, 2'b00});
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic wait_drained();
		pts.valid <= 1'b0;
		do
			@(posedge clk);
		while (results_pending != 0);
	endtask

	task automatic send_point(point_t p, logic gaps_on);
		int gap;
		gap = gaps_on ? idle_len() : 0;
		if (gap > 0) begin
			pts.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		pts.valid   <= 1'b1;
		pts.point_x <= p.x;
		pts.point_y <= p.y;
		pts.point_z <= p.z;
		do
			@(posedge clk);
		while (!pts.ready);
	endtask

	// Grid changes only between frames, with the pipeline empty
	task automatic program_grid(logic [DIM_W-1:0] w_reg, logic [DIM_W-1:0] h_reg,
		logic [THR_W-1:0] thr);
		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		apb_xfer(1'b1, REG_IMAGE_WIDTH, {(APB_DATA_W-DIM_W)'($urandom), w_reg});
		apb_xfer(1'b1, REG_IMAGE_HEIGHT, {(APB_DATA_W-DIM_W)'($urandom), h_reg});
		apb_xfer(1'b1, REG_EDGE_THRESHOLD, thr);
		apb_xfer(1'b0, REG_IMAGE_WIDTH, '0);
		apb_xfer(1'b0, REG_IMAGE_HEIGHT, '0);
		apb_xfer(1'b0, REG_EDGE_THRESHOLD, '0);
		settings_used++;
	endtask

	// A flat surface with depth jitter, outliers and some fully random points
	task automatic run_surface_frame(int w_eff, int h_eff, logic hold_once);
		logic [31:0] pitch;
		logic [31:0] jitter;
		logic [31:0] thr;
		logic [31:0] bx;
		logic [31:0] by;
		logic [31:0] bz;
		point_t      p;
		int          kind;
		int          hold_at;
		logic        gaps_on;
		pitch  = ($urandom_range(0, 7) == 0) ? 32'd0 : 32'($urandom_range(1, 1 << 18));
		jitter = (pitch == 0) ? 32'd0 : 32'($urandom_range(0, pitch));
		case ($urandom_range(0, 9))
			0:       thr = '0;
			1:       thr = '1;
			2:       thr = RST_EDGE_THRESHOLD;
			3:       thr = $urandom;
			default: thr = pitch + 32'($urandom_range(0, pitch));
		endcase
		bx      = $urandom;
		by      = $urandom;
		bz      = $urandom;
		gaps_on = ($urandom_range(0, 3) != 0);
		hold_at = hold_once ? $urandom_range(0, w_eff * h_eff - 1) : -1;
		program_grid(dim_reg_for(w_eff, MAX_WIDTH), dim_reg_for(h_eff, MAX_HEIGHT), thr);
		for (int r = 0; r < h_eff; r++) begin
			for (int c = 0; c < w_eff; c++) begin
				kind = $urandom_range(0, 31);
				if (kind == 0) begin
					p = {$urandom, $urandom, $urandom};
				end else begin
					p.x = bx + 32'(c) * pitch;
					p.y = by + 32'(r) * pitch;
					p.z = (kind == 1) ? 32'($urandom) : bz + 32'($urandom_range(0, jitter));
				end
				// hold the stream until every expected triangle has come out
				if (r * w_eff + c == hold_at)
					wait_drained();
				send_point(p, gaps_on);
			end
		end
	endtask

	// Result side backpressure
	initial begin : result_drain
		int run_len;
		int stall_len;
		int pick;
		tris.ready = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			pick      = $urandom_range(0, 19);
			run_len   = (pick == 0) ? $urandom_range(100, 300) : $urandom_range(1, 8);
			stall_len = (pick == 0) ? 0 : idle_len();
			tris.ready <= 1'b1;
			repeat (run_len) @(posedge clk);
			if (stall_len > 0) begin
				tris.ready <= 1'b0;
				repeat (stall_len) @(posedge clk);
			end
		end
	end

	initial begin : watchdog
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("TB_ERROR");
		$finish;
	end

	initial begin : stimulus
		point_t p;
		int     w_eff;
		int     h_eff;
		int     random_sent;
		int     frame_no;
		arst_n      = 1'b0;
		psel        = 1'b0;
		penable     = 1'b0;
		pwrite      = 1'b0;
		paddr       = '0;
		pwdata      = '0;
		pts.valid   = 1'b0;
		pts.point_x = '0;
		pts.point_y = '0;
		pts.point_z = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Opposite full-scale corners: the long edge sums exceed the limit, nothing passes
		program_grid(DIM_W'(0), DIM_W'(1), '1);
		for (int k = 0; k < 4; k++) begin
			p = (k == 0 || k == 3) ? {3{32'h7FFF_FFFF}} : {3{32'h8000_0000}};
			send_point(p, 1'b0);
		end

		// Edge exactly at the full-scale threshold passes, one unit over fails
		program_grid(DIM_W'(1), DIM_W'(0), '1);
		p = {32'h7FFF_FFFF, 32'd0, 32'd0};
		send_point(p, 1'b1);
		p = {32'h8000_0000, 32'd0, 32'd0};
		send_point(p, 1'b1);
		p = {32'h7FFF_FFFF, 32'd1, 32'd0};
		send_point(p, 1'b1);
		p = {32'h8000_0000, 32'd0, 32'd0};
		send_point(p, 1'b1);

		// Zero threshold on a flat 3x3 grid, both diagonals, two points offset by one LSB
		program_grid(DIM_W'(3), DIM_W'(3), '0);
		for (int k = 0; k < 9; k++) begin
			p = '0;
			if (k == 1)
				p.x = 1;
			if (k == 7)
				p.z = 1;
			send_point(p, 1'b1);
		end

		// Random surfaces on small grids
		random_sent = 0;
		frame_no    = 0;
		while (random_sent < RANDOM_ITEMS) begin
			if ($urandom_range(0, 3) == 0) begin
				w_eff = $urandom_range(2, 3);
				h_eff = $urandom_range(2, 12);
			end else begin
				w_eff = $urandom_range(2, 12);
				h_eff = $urandom_range(2, 5);
			end
			run_surface_frame(w_eff, h_eff, (frame_no % 5) == 1);
			random_sent += w_eff * h_eff;
			frame_no++;
		end

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Ran %0d points through %0d grid settings,", points_seen, settings_used);
		$display("low-clamped sizes and threshold extremes included.");
		$display("Checked %0d triangles and every register read-back.", tris_checked);
		if (fail_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
